// ----- src/prime_power_shape_codec_macros.svh -----
// Assertion macros for the prime-power shape codec.
// Used by the codec top level and its divider; expects clk and rst in scope.
`ifndef PRIME_POWER_SHAPE_CODEC_MACROS_SVH
`define PRIME_POWER_SHAPE_CODEC_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define PPSC_ASSERT_COMB(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppsc: same-cycle check failed");
// Next-cycle implication.
`define PPSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ppsc: next-cycle check failed");
`else
`define PPSC_ASSERT_COMB(label, ante, cons)
`define PPSC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- src/ppsc_pkg.sv -----
// Shared types, constants and helper functions of the prime-power shape codec.
// No dependencies; used by ppsc_mul_unit, ppsc_div_unit and the top level.
package ppsc_pkg;

  localparam int NUM_DIMS    = 5;
  localparam int DIM_W       = 3;
  localparam int SIG_W       = 128;
  localparam int HALF_W      = SIG_W / 2;
  localparam int PRIME_W     = 4;
  localparam int LIM_W       = 5;
  localparam int CNT_W       = LIM_W + 1;
  localparam int EXP_IN_W    = 8;
  localparam int EXP_OUT_W   = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int BYTE_W      = 8;
  localparam int DIV_STEPS   = SIG_W / BYTE_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_MODALITY = 3'd0,
    CFG_MAX_DEPTH    = 3'd1,
    CFG_MAX_CONTEXT  = 3'd2,
    CFG_MAX_SALIENCE = 3'd3,
    CFG_MAX_AUTONOMY = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENC,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic               start;
    logic [PRIME_W-1:0] prime;
  } div_ctrl_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [PRIME_W-1:0] rem;
  } div_stat_t;

  function automatic logic [PRIME_W-1:0] prime_of(input logic [DIM_W-1:0] dim);
    logic [PRIME_W-1:0] p;
    case (dim)
      3'd0:    p = 4'd2;
      3'd1:    p = 4'd3;
      3'd2:    p = 4'd5;
      3'd3:    p = 4'd7;
      3'd4:    p = 4'd11;
      default: p = 4'd2;
    endcase
    return p;
  endfunction

  function automatic logic [LIM_W-1:0] lim_reset(input logic [DIM_W-1:0] dim);
    logic [LIM_W-1:0] v;
    case (dim)
      3'd1, 3'd2: v = 5'd16;
      default:    v = 5'd8;
    endcase
    return v;
  endfunction

endpackage

// ----- src/ppsc_mul_unit.sv -----
// Multiplies the 128-bit running product by a small prime and flags overflow.
// Depends on ppsc_pkg.
module ppsc_mul_unit (
  input  logic [ppsc_pkg::SIG_W-1:0]   acc,
  input  logic [ppsc_pkg::PRIME_W-1:0] prime,
  output logic [ppsc_pkg::SIG_W-1:0]   prod,
  output logic                         ovf
);

  localparam int WIDE_W = ppsc_pkg::SIG_W + ppsc_pkg::PRIME_W;

  logic [WIDE_W-1:0] wide;

  assign wide = WIDE_W'(acc) * WIDE_W'(prime);
  assign prod = wide[ppsc_pkg::SIG_W-1:0];
  // anything above bit 127 means the product no longer fits
  assign ovf  = |wide[WIDE_W-1:ppsc_pkg::SIG_W];

endmodule

// ----- src/ppsc_div_unit.sv -----
// Byte-serial divider of a 128-bit value by a small prime, MSB byte first.
// Depends on ppsc_pkg and prime_power_shape_codec_macros.svh.
`include "prime_power_shape_codec_macros.svh"

module ppsc_div_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  ppsc_pkg::div_ctrl_t         ctrl,
  input  logic [ppsc_pkg::SIG_W-1:0]  num_in,
  output ppsc_pkg::div_stat_t         stat,
  output logic [ppsc_pkg::SIG_W-1:0]  quo
);

  logic [ppsc_pkg::SIG_W-1:0]     num;
  logic [ppsc_pkg::PRIME_W-1:0]   rem;
  logic [ppsc_pkg::PRIME_W-1:0]   rem_next;
  logic [ppsc_pkg::PRIME_W-1:0]   prime;
  logic [ppsc_pkg::BYTE_W-1:0]    qbyte;
  logic [ppsc_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy;
  logic                           done_r;

  // eight restoring steps on a narrow remainder
  always_comb begin
    logic [ppsc_pkg::PRIME_W:0]   t;
    logic [ppsc_pkg::PRIME_W-1:0] r;
    r     = rem;
    qbyte = '0;
    for (int j = 0; j < ppsc_pkg::BYTE_W; j++) begin
      t = {r, num[ppsc_pkg::SIG_W-1-j]};
      if (t >= {1'b0, prime}) begin
        qbyte[ppsc_pkg::BYTE_W-1-j] = 1'b1;
        t = t - {1'b0, prime};
      end
      r = t[ppsc_pkg::PRIME_W-1:0];
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
      cnt    <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ppsc_pkg::DIV_CNT_W'(ppsc_pkg::DIV_STEPS - 1)) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      num   <= num_in;
      prime <= ctrl.prime;
      rem   <= '0;
    end else if (busy) begin
      num <= num << ppsc_pkg::BYTE_W;
      quo <= {quo[ppsc_pkg::SIG_W-ppsc_pkg::BYTE_W-1:0], qbyte};
      rem <= rem_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done_r;
  assign stat.rem  = rem;

  `PPSC_ASSERT_COMB(a_start_when_idle, ctrl.start, !busy && !done_r)
  `PPSC_ASSERT_NEXT(a_start_goes_busy, ctrl.start, busy && !done_r)
  `PPSC_ASSERT_COMB(a_rem_below_prime, busy || done_r, rem < prime)

endmodule

// ----- src/prime_power_shape_codec.sv -----
// Top level of the prime-power shape codec: config registers, sequencer, result register.
// Depends on ppsc_pkg, ppsc_mul_unit, ppsc_div_unit and the assertion macro header.
//
//   channel  signals                                    direction
//   in       in_valid/in_ready, opcode, in_*            to block
//   out      out_valid/out_ready, ok, out_*             from block
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data   to block
//
// Encode: one multiply by a prime per cycle.
// Decode: trial divisions, one per factor divided out and one failing trial per prime,
// stopping early once an exponent passes its maximum or a prime does not divide at all;
// the byte-serial divider works through each 128-bit division one byte at a time.
// Reset restores the maxima to 8, 16, 16, 8, 8; no clearing pass. cfg_ready stays high.
// One item at a time; a new item is taken while the last result waits on out_ready.
`include "prime_power_shape_codec_macros.svh"

module prime_power_shape_codec (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              opcode,
  input  logic [ppsc_pkg::EXP_IN_W-1:0]     in_modality,
  input  logic [ppsc_pkg::EXP_IN_W-1:0]     in_depth,
  input  logic [ppsc_pkg::EXP_IN_W-1:0]     in_context,
  input  logic [ppsc_pkg::EXP_IN_W-1:0]     in_salience,
  input  logic [ppsc_pkg::EXP_IN_W-1:0]     in_autonomy,
  input  logic [ppsc_pkg::HALF_W-1:0]       in_sig_hi,
  input  logic [ppsc_pkg::HALF_W-1:0]       in_sig_lo,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              ok,
  output logic [ppsc_pkg::HALF_W-1:0]       out_sig_hi,
  output logic [ppsc_pkg::HALF_W-1:0]       out_sig_lo,
  output logic [ppsc_pkg::EXP_OUT_W-1:0]    out_modality,
  output logic [ppsc_pkg::EXP_OUT_W-1:0]    out_depth,
  output logic [ppsc_pkg::EXP_OUT_W-1:0]    out_context,
  output logic [ppsc_pkg::EXP_OUT_W-1:0]    out_salience,
  output logic [ppsc_pkg::EXP_OUT_W-1:0]    out_autonomy,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ppsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppsc_pkg::LIM_W-1:0]        cfg_data
);

  localparam int NUM_DIMS = ppsc_pkg::NUM_DIMS;
  localparam int DIM_W    = ppsc_pkg::DIM_W;
  localparam int SIG_W    = ppsc_pkg::SIG_W;
  localparam int LIM_W    = ppsc_pkg::LIM_W;
  localparam int CNT_W    = ppsc_pkg::CNT_W;

  ppsc_pkg::state_t state, state_next;

  logic [LIM_W-1:0]              lim     [NUM_DIMS];
  logic [LIM_W-1:0]              exps    [NUM_DIMS];
  logic [LIM_W-1:0]              dec_exp [NUM_DIMS];
  logic [ppsc_pkg::EXP_IN_W-1:0] in_exp  [NUM_DIMS];
  logic [SIG_W-1:0]              acc;
  logic [DIM_W-1:0]              dim;
  logic [CNT_W-1:0]              cnt;
  logic [CNT_W-1:0]              cnt_inc;
  logic                          op;
  logic                          good;

  logic                          in_xfer;
  logic                          out_free;
  logic                          enc_ok_in;
  logic                          dec_ok_in;
  logic                          dim_end;
  logic [LIM_W-1:0]              lim_cur;
  logic [LIM_W-1:0]              exp_cur;
  logic [ppsc_pkg::PRIME_W-1:0]  prime_cur;
  logic                          enc_step_done;
  logic                          lim_over;

  logic [SIG_W-1:0]              mul_prod;
  logic                          mul_ovf;
  ppsc_pkg::div_ctrl_t           div_ctrl;
  ppsc_pkg::div_stat_t           div_stat;
  logic [SIG_W-1:0]              div_quo;

  logic [SIG_W-1:0]                   res_sig;
  logic [ppsc_pkg::EXP_OUT_W-1:0]     res_exp [NUM_DIMS];
  logic                               res_sig_zero;
  logic                               res_exp_zero;

  assign in_exp[0] = in_modality;
  assign in_exp[1] = in_depth;
  assign in_exp[2] = in_context;
  assign in_exp[3] = in_salience;
  assign in_exp[4] = in_autonomy;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ppsc_pkg::ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DIMS; i++) begin
        lim[i] <= ppsc_pkg::lim_reset(DIM_W'(i));
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (ppsc_pkg::cfg_idx_t'(cfg_index))
        ppsc_pkg::CFG_MAX_MODALITY: lim[0] <= {1'b0, cfg_data[LIM_W-2:0]};
        ppsc_pkg::CFG_MAX_DEPTH:    lim[1] <= cfg_data;
        ppsc_pkg::CFG_MAX_CONTEXT:  lim[2] <= cfg_data;
        ppsc_pkg::CFG_MAX_SALIENCE: lim[3] <= {1'b0, cfg_data[LIM_W-2:0]};
        ppsc_pkg::CFG_MAX_AUTONOMY: lim[4] <= {1'b0, cfg_data[LIM_W-2:0]};
        default: ;
      endcase
    end
  end

  // range check of the incoming exponents and the trivial-signature test
  always_comb begin
    enc_ok_in = 1'b1;
    for (int i = 0; i < NUM_DIMS; i++) begin
      if (in_exp[i] == '0 || in_exp[i] > ppsc_pkg::EXP_IN_W'(lim[i])) begin
        enc_ok_in = 1'b0;
      end
    end
  end
  assign dec_ok_in = (|in_sig_hi) || (|in_sig_lo[ppsc_pkg::HALF_W-1:1]);

  assign dim_end   = (dim == DIM_W'(NUM_DIMS));
  assign lim_cur   = dim_end ? '0 : lim[dim];
  assign exp_cur   = dim_end ? '0 : exps[dim];
  assign prime_cur = ppsc_pkg::prime_of(dim);
  assign cnt_inc   = cnt + 1'b1;
  assign enc_step_done = (cnt == CNT_W'(exp_cur));
  assign lim_over  = (cnt_inc > CNT_W'(lim_cur));

  ppsc_mul_unit u_mul (
    .acc   (acc),
    .prime (prime_cur),
    .prod  (mul_prod),
    .ovf   (mul_ovf)
  );

  assign div_ctrl.start = (state == ppsc_pkg::ST_DIV_START) && !dim_end;
  assign div_ctrl.prime = prime_cur;

  ppsc_div_unit u_div (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (div_ctrl),
    .num_in (acc),
    .stat   (div_stat),
    .quo    (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppsc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ppsc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (opcode == ppsc_pkg::OP_DECODE) begin
            state_next = dec_ok_in ? ppsc_pkg::ST_DIV_START : ppsc_pkg::ST_FINISH;
          end else begin
            state_next = enc_ok_in ? ppsc_pkg::ST_ENC : ppsc_pkg::ST_FINISH;
          end
        end
      end
      ppsc_pkg::ST_ENC: begin
        if (dim_end || (!enc_step_done && mul_ovf)) begin
          state_next = ppsc_pkg::ST_FINISH;
        end
      end
      ppsc_pkg::ST_DIV_START: begin
        state_next = dim_end ? ppsc_pkg::ST_FINISH : ppsc_pkg::ST_DIV_WAIT;
      end
      ppsc_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) begin
          if ((div_stat.rem == '0 && lim_over) || (div_stat.rem != '0 && cnt == '0)) begin
            state_next = ppsc_pkg::ST_FINISH;
          end else begin
            state_next = ppsc_pkg::ST_DIV_START;
          end
        end
      end
      ppsc_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = ppsc_pkg::ST_IDLE;
        end
      end
      default: state_next = ppsc_pkg::ST_IDLE;
    endcase
  end

  // working registers of the sequencer
  always_ff @(posedge clk) begin
    case (state)
      ppsc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          op   <= opcode;
          good <= (opcode == ppsc_pkg::OP_DECODE) ? dec_ok_in : enc_ok_in;
          acc  <= (opcode == ppsc_pkg::OP_DECODE) ? {in_sig_hi, in_sig_lo} : SIG_W'(1);
          dim  <= '0;
          cnt  <= '0;
          for (int i = 0; i < NUM_DIMS; i++) begin
            exps[i]    <= in_exp[i][LIM_W-1:0];
            dec_exp[i] <= '0;
          end
        end
      end
      ppsc_pkg::ST_ENC: begin
        if (!dim_end) begin
          if (enc_step_done) begin
            dim <= dim + 1'b1;
            cnt <= '0;
          end else if (mul_ovf) begin
            good <= 1'b0;
          end else begin
            acc <= mul_prod;
            cnt <= cnt_inc;
          end
        end
      end
      ppsc_pkg::ST_DIV_START: begin
        // residue must be exactly one once every prime is divided out
        if (dim_end && acc != SIG_W'(1)) begin
          good <= 1'b0;
        end
      end
      ppsc_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) begin
          if (div_stat.rem == '0) begin
            acc <= div_quo;
            cnt <= cnt_inc;
            if (lim_over) begin
              good <= 1'b0;
            end
          end else begin
            dec_exp[dim] <= cnt[LIM_W-1:0];
            dim          <= dim + 1'b1;
            cnt          <= '0;
            if (cnt == '0) begin
              good <= 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ppsc_pkg::ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ppsc_pkg::ST_FINISH && out_free) begin
      ok      <= good;
      res_sig <= (good && op == ppsc_pkg::OP_ENCODE) ? acc : '0;
      for (int i = 0; i < NUM_DIMS; i++) begin
        res_exp[i] <= (good && op == ppsc_pkg::OP_DECODE) ?
                      ppsc_pkg::EXP_OUT_W'(dec_exp[i]) : '0;
      end
    end
  end

  assign out_sig_hi   = res_sig[SIG_W-1:ppsc_pkg::HALF_W];
  assign out_sig_lo   = res_sig[ppsc_pkg::HALF_W-1:0];
  assign out_modality = res_exp[0];
  assign out_depth    = res_exp[1];
  assign out_context  = res_exp[2];
  assign out_salience = res_exp[3];
  assign out_autonomy = res_exp[4];

  assign res_sig_zero = (out_sig_hi == '0) && (out_sig_lo == '0);
  assign res_exp_zero = (out_modality == '0) && (out_depth == '0) && (out_context == '0) &&
                        (out_salience == '0) && (out_autonomy == '0);

  `PPSC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `PPSC_ASSERT_COMB(a_reject_is_zero, out_valid && !ok, res_sig_zero && res_exp_zero)
  `PPSC_ASSERT_COMB(a_ok_one_kind, out_valid && ok, res_sig_zero != (out_modality == '0))

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for prime_power_shape_codec: encode and decode of 128-bit
// prime-power signatures under several limit settings, with random input and output stalls.
// Depends on ppsc_pkg and the codec RTL only.
module tb_top;
  import ppsc_pkg::*;

  localparam logic [NUM_DIMS-1:0][PRIME_W-1:0] PRIME = {4'd11, 4'd7, 4'd5, 4'd3, 4'd2};
  localparam logic [NUM_DIMS-1:0][LIM_W-1:0] LIM_MASK = {5'h0F, 5'h0F, 5'h1F, 5'h1F, 5'h0F};
  localparam logic [NUM_DIMS-1:0][LIM_W-1:0] LIM_RESET = {5'd8, 5'd8, 5'd16, 5'd16, 5'd8};
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 100;

  // Exponent index 0 is the power of 2, index 4 the power of 11.
  typedef struct packed {
    logic                               op;
    logic [NUM_DIMS-1:0][EXP_IN_W-1:0]  expo;
    logic [HALF_W-1:0]                  sig_hi;
    logic [HALF_W-1:0]                  sig_lo;
  } shape_req_t;

  typedef struct packed {
    logic                               ok;
    logic [HALF_W-1:0]                  sig_hi;
    logic [HALF_W-1:0]                  sig_lo;
    logic [NUM_DIMS-1:0][EXP_OUT_W-1:0] expo;
  } shape_result_t;

  typedef struct packed {
    shape_req_t    req;
    logic          known;
    shape_result_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_ready, opcode;
  logic [EXP_IN_W-1:0] in_modality, in_depth, in_context, in_salience, in_autonomy;
  logic [HALF_W-1:0] in_sig_hi, in_sig_lo;
  logic out_valid, ok;
  logic out_ready = 1'b0;
  logic [HALF_W-1:0] out_sig_hi, out_sig_lo;
  logic [EXP_OUT_W-1:0] out_modality, out_depth, out_context, out_salience, out_autonomy;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LIM_W-1:0] cfg_data;

  logic [NUM_DIMS-1:0][LIM_W-1:0] shape_max;
  shape_result_t shape_results_q [$];
  dir_row_t dir_tab [$];
  int fail_cnt = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;

  prime_power_shape_codec uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
    .in_modality(in_modality), .in_depth(in_depth), .in_context(in_context),
    .in_salience(in_salience), .in_autonomy(in_autonomy),
    .in_sig_hi(in_sig_hi), .in_sig_lo(in_sig_lo),
    .out_valid(out_valid), .out_ready(out_ready), .ok(ok),
    .out_sig_hi(out_sig_hi), .out_sig_lo(out_sig_lo),
    .out_modality(out_modality), .out_depth(out_depth), .out_context(out_context),
    .out_salience(out_salience), .out_autonomy(out_autonomy),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic shape_result_t mk_res(input logic okv, input logic [HALF_W-1:0] hi,
      input logic [HALF_W-1:0] lo, input logic [EXP_OUT_W-1:0] m, input logic [EXP_OUT_W-1:0] d,
      input logic [EXP_OUT_W-1:0] c, input logic [EXP_OUT_W-1:0] s,
      input logic [EXP_OUT_W-1:0] a);
    shape_result_t r;
    r.ok = okv;
    r.sig_hi = hi;
    r.sig_lo = lo;
    r.expo = {a, s, c, d, m};
    return r;
  endfunction

  function automatic dir_row_t mk_row(input logic op, input logic [EXP_IN_W-1:0] m,
      input logic [EXP_IN_W-1:0] d, input logic [EXP_IN_W-1:0] c, input logic [EXP_IN_W-1:0] s,
      input logic [EXP_IN_W-1:0] a, input logic [HALF_W-1:0] hi, input logic [HALF_W-1:0] lo,
      input logic known, input shape_result_t want);
    dir_row_t row;
    row.req.op = op;
    row.req.expo = {a, s, c, d, m};
    row.req.sig_hi = hi;
    row.req.sig_lo = lo;
    row.known = known;
    row.want = want;
    return row;
  endfunction

  // Append one row to the directed table.
  task automatic add_row(input dir_row_t row);
    dir_tab = {dir_tab, row};
  endtask

  function automatic logic shape_fits(input logic [NUM_DIMS-1:0][EXP_IN_W-1:0] e);
    for (int i = 0; i < NUM_DIMS; i++)
      if (e[i] == '0 || e[i] > shape_max[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Callers cap exponents of 2, 7, 11 at 16 and of 3, 5 at 32, so 256 bits never wrap.
  function automatic logic [255:0] prime_product(input logic [NUM_DIMS-1:0][EXP_IN_W-1:0] e);
    logic [255:0] p;
    p = 256'd1;
    for (int i = 0; i < NUM_DIMS; i++)
      for (int k = 0; k < e[i]; k++) p = p * PRIME[i];
    return p;
  endfunction

  function automatic shape_result_t codec_predict(input shape_req_t r);
    shape_result_t res;
    logic [255:0] prod;
    logic [SIG_W-1:0] rest;
    logic [NUM_DIMS-1:0][EXP_IN_W-1:0] found;
    res = '0;
    if (r.op == OP_ENCODE) begin
      if (!shape_fits(r.expo)) return res;
      prod = prime_product(r.expo);
      if (prod[255:SIG_W] != '0) return res;
      res.ok = 1'b1;
      res.sig_hi = prod[SIG_W-1:HALF_W];
      res.sig_lo = prod[HALF_W-1:0];
      return res;
    end
    rest = {r.sig_hi, r.sig_lo};
    if (rest <= 128'd1) return res;
    for (int i = 0; i < NUM_DIMS; i++) begin
      found[i] = '0;
      while (rest % PRIME[i] == 0) begin
        rest = rest / PRIME[i];
        found[i] = found[i] + 8'd1;
      end
    end
    if (rest != 128'd1 || !shape_fits(found)) return res;
    res.ok = 1'b1;
    for (int i = 0; i < NUM_DIMS; i++) res.expo[i] = found[i][EXP_OUT_W-1:0];
    return res;
  endfunction

  // Mostly small exponents keep decode runs short; the full range still shows up.
  function automatic logic [EXP_IN_W-1:0] pick_exp(input int i);
    int top;
    top = (shape_max[i] == 0) ? 1 : shape_max[i];
    if ($urandom_range(0, 3) != 0 && top > 4) top = 4;
    return EXP_IN_W'($urandom_range(1, top));
  endfunction

  function automatic logic [SIG_W-1:0] valid_sig();
    logic [NUM_DIMS-1:0][EXP_IN_W-1:0] e;
    logic [255:0] p;
    p = '0;
    for (int t = 0; t < 8; t++) begin
      for (int i = 0; i < NUM_DIMS; i++) e[i] = pick_exp(i);
      p = prime_product(e);
      if (p[255:SIG_W] == '0) return p[SIG_W-1:0];
    end
    return p[SIG_W-1:0];
  endfunction

  function automatic shape_req_t make_item();
    shape_req_t r;
    logic [NUM_DIMS-1:0][EXP_IN_W-1:0] e;
    logic [255:0] p;
    int kind, d;
    r.sig_hi = {$urandom, $urandom};
    r.sig_lo = {$urandom, $urandom};
    for (int i = 0; i < NUM_DIMS; i++) r.expo[i] = EXP_IN_W'($urandom_range(0, 255));
    kind = $urandom_range(0, 99);
    d = $urandom_range(0, NUM_DIMS - 1);
    r.op = (kind < 35 || (kind >= 70 && kind < 80)) ? OP_ENCODE : OP_DECODE;
    if (kind < 35) begin
      for (int i = 0; i < NUM_DIMS; i++) r.expo[i] = pick_exp(i);
    end else if (kind < 70) begin
      {r.sig_hi, r.sig_lo} = valid_sig();
    end else if (kind < 75) begin
      // raw exponents, mostly out of range
    end else if (kind < 80) begin
      for (int i = 0; i < NUM_DIMS; i++) r.expo[i] = pick_exp(i);
      r.expo[d] = $urandom_range(0, 1) ? 8'd0 : EXP_IN_W'(shape_max[d]) + 8'd1;
    end else if (kind < 85) begin
      {r.sig_hi, r.sig_lo} = valid_sig() * ($urandom_range(0, 1) ? 13 : 17);
    end else if (kind < 90) begin
      for (int i = 0; i < NUM_DIMS; i++) e[i] = pick_exp(i);
      e[d] = $urandom_range(0, 1) ? 8'd0 : EXP_IN_W'(shape_max[d]) + 8'd1;
      p = prime_product(e);
      {r.sig_hi, r.sig_lo} = p[SIG_W-1:0];
    end else if (kind < 95) begin
      if ($urandom_range(0, 1)) {r.sig_hi, r.sig_lo} = SIG_W'($urandom_range(0, 3));
    end else begin
      {r.sig_hi, r.sig_lo} = 128'd1 << $urandom_range(0, SIG_W - 1);
    end
    return r;
  endfunction

  task automatic send_req(input shape_req_t r, input logic known, input shape_result_t want);
    shape_result_t exp_res;
    @(negedge clk);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= r.op;
    in_modality <= r.expo[0];
    in_depth <= r.expo[1];
    in_context <= r.expo[2];
    in_salience <= r.expo[3];
    in_autonomy <= r.expo[4];
    in_sig_hi <= r.sig_hi;
    in_sig_lo <= r.sig_lo;
    do @(posedge clk); while (!in_ready);
    exp_res = known ? want : codec_predict(r);
    shape_results_q = {shape_results_q, exp_res};
  endtask

  // Drop valid and hold until every outstanding result has been taken.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (shape_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [LIM_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_DIMS) shape_max[idx] = val & LIM_MASK[idx];
  endtask

  task automatic apply_limits(input int ph);
    case (ph)
      1: begin
        // 4-bit registers keep only the low bits; unmapped indexes must be ignored
        for (int i = 0; i < NUM_DIMS; i++) cfg_write(cfg_idx_t'(i), 5'h1F);
        for (int i = NUM_DIMS; i < 2 ** CFG_IDX_W; i++)
          cfg_write(CFG_IDX_W'(i), LIM_W'($urandom_range(0, 31)));
      end
      2: begin
        cfg_write(CFG_MAX_MODALITY, 5'd1);
        cfg_write(CFG_MAX_DEPTH, 5'd1);
        cfg_write(CFG_MAX_CONTEXT, 5'd1);
        cfg_write(CFG_MAX_SALIENCE, 5'd1);
        cfg_write(CFG_MAX_AUTONOMY, 5'd1);
      end
      5: begin
        for (int i = 0; i < NUM_DIMS; i++) cfg_write(cfg_idx_t'(i), LIM_W'($urandom_range(0, 31)));
        cfg_write(CFG_IDX_W'($urandom_range(NUM_DIMS, 2 ** CFG_IDX_W - 1)), 5'd0);
      end
      6: for (int i = 0; i < NUM_DIMS; i++) cfg_write(cfg_idx_t'(i), LIM_RESET[i]);
      default: begin
        for (int i = 0; i < NUM_DIMS; i++)
          cfg_write(cfg_idx_t'(i), LIM_W'($urandom_range(1, LIM_RESET[i])));
        // a zero maximum rejects everything
        if (ph == 4) cfg_write(cfg_idx_t'($urandom_range(0, NUM_DIMS - 1)), 5'd0);
      end
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_result(input shape_result_t want, input shape_result_t got);
    if (got.ok !== want.ok) begin
      $display("%0t: ok mismatch: expected %0b, actual %0b", $time, want.ok, got.ok);
      fail_cnt++;
    end
    if (got.sig_hi !== want.sig_hi) begin
      $display("%0t: out_sig_hi mismatch: expected %h, actual %h", $time, want.sig_hi,
               got.sig_hi);
      fail_cnt++;
    end
    if (got.sig_lo !== want.sig_lo) begin
      $display("%0t: out_sig_lo mismatch: expected %h, actual %h", $time, want.sig_lo,
               got.sig_lo);
      fail_cnt++;
    end
    for (int i = 0; i < NUM_DIMS; i++)
      if (got.expo[i] !== want.expo[i]) begin
        $display("%0t: exponent of %0d mismatch: expected %0d, actual %0d", $time, PRIME[i],
                 want.expo[i], got.expo[i]);
        fail_cnt++;
      end
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= out_idle_pct);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (shape_results_q.size() == 0) begin
        $display("%0t: unexpected result transfer: expected none, actual ok=%0b", $time, ok);
        fail_cnt++;
      end else begin
        check_result(shape_results_q.pop_front(),
                     mk_res(ok, out_sig_hi, out_sig_lo, out_modality, out_depth, out_context,
                            out_salience, out_autonomy));
      end
    end
  end

  initial begin
    #100_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [255:0] p_max, p_low2;
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = OP_ENCODE;
    {in_modality, in_depth, in_context, in_salience, in_autonomy} = '0;
    in_sig_hi = '0;
    in_sig_lo = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MAX_MODALITY;
    cfg_data = '0;
    shape_max = LIM_RESET;
    // packed order below is {11, 7, 5, 3, 2}
    p_max = prime_product({8'd8, 8'd8, 8'd16, 8'd16, 8'd8});
    p_low2 = prime_product({8'd8, 8'd8, 8'd16, 8'd16, 8'd1});
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // limits are at their reset values here
    add_row(mk_row(OP_ENCODE, 1, 1, 1, 1, 1, '0, '0, 1'b1,
                   mk_res(1'b1, '0, 64'd2310, 0, 0, 0, 0, 0)));
    add_row(mk_row(OP_ENCODE, 1, 1, 1, 1, 1, '1, '1, 1'b1,
                   mk_res(1'b1, '0, 64'd2310, 0, 0, 0, 0, 0)));
    add_row(mk_row(OP_ENCODE, 0, 1, 1, 1, 1, '0, '0, 1'b1, '0));
    add_row(mk_row(OP_ENCODE, 1, 1, 1, 1, 0, '0, '0, 1'b1, '0));
    add_row(mk_row(OP_ENCODE, 9, 1, 1, 1, 1, '0, '0, 1'b1, '0));
    add_row(mk_row(OP_ENCODE, 1, 17, 1, 1, 1, '0, '0, 1'b1, '0));
    add_row(mk_row(OP_ENCODE, 255, 255, 255, 255, 255, '0, '0, 1'b1, '0));
    add_row(mk_row(OP_ENCODE, 8, 16, 16, 8, 8, '0, '0, 1'b0, '0));
    add_row(mk_row(OP_ENCODE, 8, 1, 1, 1, 1, '0, '0, 1'b0, '0));
    add_row(mk_row(OP_DECODE, 0, 0, 0, 0, 0, '0, '0, 1'b1, '0));
    add_row(mk_row(OP_DECODE, 0, 0, 0, 0, 0, '0, 64'd1, 1'b1, '0));
    add_row(mk_row(OP_DECODE, 0, 0, 0, 0, 0, '0, 64'd2, 1'b1, '0));
    add_row(mk_row(OP_DECODE, 255, 255, 255, 255, 255, '0, 64'd2310, 1'b1,
                   mk_res(1'b1, '0, '0, 1, 1, 1, 1, 1)));
    add_row(mk_row(OP_DECODE, 0, 0, 0, 0, 0, '0, 64'd30030, 1'b1, '0));
    add_row(mk_row(OP_DECODE, 0, 0, 0, 0, 0, 64'h8000_0000_0000_0000, '0, 1'b1, '0));
    add_row(mk_row(OP_DECODE, 0, 0, 0, 0, 0, 64'd1, '0, 1'b1, '0));
    add_row(mk_row(OP_DECODE, 0, 0, 0, 0, 0, '1, '1, 1'b0, '0));
    add_row(mk_row(OP_DECODE, 0, 0, 0, 0, 0, '0, 64'd591360, 1'b1, '0));
    add_row(mk_row(OP_DECODE, 0, 0, 0, 0, 0, p_max[127:64], p_max[63:0], 1'b0, '0));
    add_row(mk_row(OP_DECODE, 0, 0, 0, 0, 0, p_low2[127:64], p_low2[63:0], 1'b0, '0));

    in_idle_pct = 17;
    out_idle_pct = 48;
    foreach (dir_tab[i]) send_req(dir_tab[i].req, dir_tab[i].known, dir_tab[i].want);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 3) begin
        in_idle_pct = 17;
        out_idle_pct = 48;
      end else if (ph < 6) begin
        in_idle_pct = 48;
        out_idle_pct = 17;
      end else begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      if (ph != 0) apply_limits(ph);
      for (int n = 0; n < PHASE_ITEMS; n++) send_req(make_item(), 1'b0, '0);
      settle();
    end

    // catch any stray result transfer
    repeat (200) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
